>>> rtl/lph_pkg.sv
`timescale 1ns / 1ps
package lph_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int SIZE_W  = 5;
    localparam int SLOT_W  = 4;

    // Defaults
    localparam int DEPTH_DEF  = 16;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Classified request passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] home;
        logic              refused;
    } t_req;

endpackage

>>> rtl/lph_ram.sv
`timescale 1ns / 1ps
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one port, registered read on the other
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lph_front.sv
`timescale 1ns / 1ps
module lph_front
    import lph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_op,
    input  logic [KEY_W-1:0]  i_key_value,
    input  logic              i_hold,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output t_req              o_req
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        r_cnt;
    logic [31:0]       r_div;
    logic [SIZE_W-1:0] r_rem;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic              r_refused;
    logic [SIZE_W-1:0] n_rem;
    logic              accept;
    logic              bad_req;

    assign o_busy  = i_hold || (r_state != F_IDLE);
    assign accept  = i_start && !o_busy;
    assign bad_req = (i_key_value == '0) ||
                     !(i_op inside {OP_INSERT, OP_DELETE, OP_SEARCH});
    assign o_push  = (r_state == F_PUSH) && !i_full;

    assign o_req.op      = r_op;
    assign o_req.key     = r_key;
    assign o_req.home    = r_rem;
    assign o_req.refused = r_refused;

    // fold eight key bits into the remainder, most significant first
    always_comb begin
        logic [SIZE_W:0] t;
        n_rem = r_rem;
        for (int i = 0; i < 8; i++) begin
            t = {n_rem, r_div[31-i]};
            if (t >= {1'b0, i_size}) begin
                t = t - {1'b0, i_size};
            end
            n_rem = t[SIZE_W-1:0];
        end
    end

    // sequence: accept, reduce key modulo size (skipped for refused requests), hand to queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_op      <= i_op;
                        r_key     <= i_key_value;
                        r_refused <= bad_req;
                        r_rem     <= '0;
                        r_div     <= {1'b0, i_key_value};
                        r_cnt     <= '0;
                        r_state   <= bad_req ? F_PUSH : F_DIV;
                    end
                end
                F_DIV: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[23:0], 8'h00};
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/lph_queue.sv
`timescale 1ns / 1ps
module lph_queue
    import lph_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_req o_head
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    // hold entries in a two-word ring
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/lph_back.sv
`timescale 1ns / 1ps
module lph_back
    import lph_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_empty,
    input  t_req              i_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_done,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_slot_index
);

    localparam int IW = $clog2(DEPTH);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;

    logic [1:0]        r_state;
    logic [IW-1:0]     r_clr_idx;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_want;
    logic [IW-1:0]     r_rd_idx;
    logic [SIZE_W-1:0] r_rd_left;
    logic [SIZE_W-1:0] r_chk_left;
    logic              r_pv;
    logic [IW-1:0]     r_pv_idx;
    logic              r_done;
    logic              r_status;
    logic [SLOT_W-1:0] r_slot;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;
    logic              hit;
    logic              miss;
    logic [IW+4:0]     inc_w;
    logic [IW+4:0]     size_w;
    logic [IW-1:0]     next_idx;
    logic [IW+4:0]     home_w;
    logic [IW+3:0]     slot_w;

    lph_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign o_clearing = (r_state == B_CLEAR);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;

    // compare the word read last cycle
    assign hit  = (r_state == B_PROBE) && r_pv && (ram_rdata == r_want);
    assign miss = (r_state == B_PROBE) && r_pv && !hit && (r_chk_left == 5'd1);

    // step the probe index, wrap at the size in use
    assign inc_w    = {5'b00000, r_rd_idx} + (IW+5)'(1);
    assign size_w   = {{IW{1'b0}}, i_size};
    assign next_idx = (inc_w >= size_w) ? '0 : inc_w[IW-1:0];

    assign home_w = {{IW{1'b0}}, i_head.home};
    assign slot_w = {4'b0000, r_pv_idx};

    // write port: clear sweep, or update of the slot found
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pv_idx;
        ram_wdata = '0;
        if (r_state == B_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
        end else if (hit && (r_op != OP_SEARCH)) begin
            ram_we    = 1'b1;
            ram_wdata = (r_op == OP_INSERT) ? r_key : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr_idx <= '0;
            r_pv      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IW'(1);
                    if (r_clr_idx == IW'(DEPTH - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    r_pv <= 1'b0;
                    if (!i_empty) begin
                        if (i_head.refused) begin
                            r_done   <= 1'b1;
                            r_status <= 1'b1;
                            r_slot   <= '0;
                        end else begin
                            r_op       <= i_head.op;
                            r_key      <= i_head.key;
                            r_want     <= (i_head.op == OP_INSERT) ? '0 : i_head.key;
                            r_rd_idx   <= home_w[IW-1:0];
                            r_rd_left  <= i_size;
                            r_chk_left <= i_size;
                            r_state    <= B_PROBE;
                        end
                    end
                end
                B_PROBE: begin
                    // issue the next read while checking the last one
                    if (r_rd_left != '0) begin
                        r_pv      <= 1'b1;
                        r_pv_idx  <= r_rd_idx;
                        r_rd_idx  <= next_idx;
                        r_rd_left <= r_rd_left - SIZE_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_chk_left <= r_chk_left - SIZE_W'(1);
                    end
                    if (hit) begin
                        r_done   <= 1'b1;
                        r_status <= 1'b0;
                        r_slot   <= slot_w[SLOT_W-1:0];
                        r_state  <= B_IDLE;
                    end else if (miss) begin
                        r_done   <= 1'b1;
                        r_status <= 1'b1;
                        r_slot   <= '0;
                        r_state  <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;

endmodule

>>> rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Linear-probing hash table of positive keys. After reset the block sweeps
// its slot memory to zero, one slot a cycle, and holds busy high during the
// sweep. A request is taken when start is high and busy is low; its result
// shows on o_status/o_slot_index for exactly one cycle with o_done, and the
// receiver cannot hold it off. The front reduces the key modulo the size in
// use (8 bits a cycle) and hands the request to a two-word queue; the back
// probes one slot a cycle through the memory's registered read port. The
// front takes a new request once it has pushed the last one into the queue,
// so it works while the back still probes, and the slower of the two sets
// the sustained rate. Refused requests (key zero, unknown op) skip the
// reduction and the probe and report failure with slot zero. Write
// table_size only while idle.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [KEY_W-1:0]  i_key_value,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_slot_index
);

    localparam logic [SIZE_W-1:0] DEPTH_CAP = (DEPTH > 31) ? 5'd31 : SIZE_W'(DEPTH);

    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] size_used;
    logic              clearing;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_req              req;
    t_req              head;

    // hold the size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    // clamp the size in use to 1..DEPTH, and to at most 31
    always_comb begin
        size_used = r_table_size;
        if (r_table_size == '0) begin
            size_used = 5'd1;
        end else if (r_table_size > DEPTH_CAP) begin
            size_used = DEPTH_CAP;
        end
    end

    lph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_key_value (i_key_value),
        .i_hold      (clearing),
        .i_size      (size_used),
        .i_full      (full),
        .o_busy      (busy),
        .o_push      (push),
        .o_req       (req)
    );

    lph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    lph_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (size_used),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

endmodule

>>> rtl/lph_checker.sv
`timescale 1ns / 1ps
module lph_checker
    import lph_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic              o_status,
    input logic [SLOT_W-1:0] o_slot_index
);

    // a failed request reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_slot_index == '0))
        else $error("failed result with nonzero slot");

    // an accepted word keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepting a word");

    // reset starts the clear sweep
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

bind linear_probe_hash_table lph_checker u_chk (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import lph_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASES      = 13;
    localparam int PHASE_WORDS = 96;

    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX   = '1;
    localparam logic [KEY_W-1:0] KEY_NONE  = '0;

    typedef enum logic [1:0] {
        WORD_REQ,
        WORD_CFG,
        WORD_DRAIN
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [2:0]        gap;
    } t_word;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
    } t_outcome;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op         = OP_INSERT;
    logic [KEY_W-1:0]  i_key_value  = '0;
    logic              i_cfg_we     = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata  = '0;
    logic              o_done;
    logic              o_status;
    logic [SLOT_W-1:0] o_slot_index;

    // Shadow copy of the table and its size register
    logic [KEY_W-1:0]  shadow_slots [DEPTH];
    logic [SIZE_W-1:0] shadow_size;

    t_word    pending_q [$];
    t_outcome outcome_q [$];
    int       fails        = 0;
    int       gap_left     = 0;
    logic     gap_loaded   = 1'b0;
    int       quiet_cycles = 0;

    logic [SIZE_W-1:0] size_plan [$];

    linear_probe_hash_table #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_key_value (i_key_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_slot_index(o_slot_index)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return its outcome
    function automatic t_outcome hash_lookup(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        int unsigned      n;
        int unsigned      idx;
        logic [KEY_W-1:0] want;
        t_outcome         res;
        n = 32'(shadow_size);
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        res.status = 1'b1;
        res.slot   = '0;
        if (key != KEY_NONE && (op == OP_INSERT || op == OP_DELETE || op == OP_SEARCH)) begin
            want = (op == OP_INSERT) ? KEY_NONE : key;
            idx  = 32'(key) % n;
            for (int k = 0; k < n && res.status; k++) begin
                if (shadow_slots[idx] == want) begin
                    res.status = 1'b0;
                    res.slot   = idx[SLOT_W-1:0];
                    if (op == OP_INSERT) begin
                        shadow_slots[idx] = key;
                    end else if (op == OP_DELETE) begin
                        shadow_slots[idx] = KEY_NONE;
                    end
                end
                idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
        end
        return res;
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, int gap);
        t_word w;
        w.kind = WORD_REQ;
        w.op   = op;
        w.key  = key;
        w.size = '0;
        w.gap  = gap[2:0];
        pending_q.push_back(w);
    endtask

    task automatic add_ctrl(t_kind kind, logic [SIZE_W-1:0] size);
        t_word w;
        w.kind = kind;
        w.op   = OP_INSERT;
        w.key  = '0;
        w.size = size;
        w.gap  = '0;
        pending_q.push_back(w);
    endtask

    function automatic logic [OP_W-1:0] draw_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_INSERT;
        if (r < 70) return OP_DELETE;
        if (r < 94) return OP_SEARCH;
        return OP_UNUSED;
    endfunction

    // Mostly keys from a small pool so that probes collide and repeat
    function automatic logic [KEY_W-1:0] draw_key(int unsigned pool, logic [KEY_W-1:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return KEY_W'($urandom_range(1, pool));
        if (r < 70) return base + KEY_W'($urandom_range(0, pool));
        if (r < 75) return KEY_NONE;
        return KEY_W'($urandom);
    endfunction

    // Driver: take words from the pending queue, predict at acceptance
    always @(posedge i_clk) begin
        logic  nxt_start;
        logic  nxt_we;
        logic  taken;
        t_word w;
        nxt_start = start;
        nxt_we    = 1'b0;
        taken     = start && !busy;
        if (taken) begin
            outcome_q.push_back(hash_lookup(i_op, i_key_value));
            nxt_start = 1'b0;
        end
        if (i_rst_n && !nxt_start && !i_cfg_we && pending_q.size() > 0) begin
            w = pending_q[0];
            if (w.kind == WORD_REQ) begin
                if (!gap_loaded) begin
                    gap_left   = int'(w.gap);
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    void'(pending_q.pop_front());
                    gap_loaded  = 1'b0;
                    nxt_start   = 1'b1;
                    i_op        <= w.op;
                    i_key_value <= w.key;
                end
            end else if (!taken && !busy && outcome_q.size() == 0) begin
                // hold until the table is idle, then write or just move on
                void'(pending_q.pop_front());
                if (w.kind == WORD_CFG) begin
                    nxt_we      = 1'b1;
                    i_cfg_wdata <= w.size;
                    shadow_size = w.size;
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: sample each result word mid-cycle and check it
    always @(negedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d",
                         $time, o_status, o_slot_index);
                fails++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                    fails++;
                end
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                             $time, want.slot, o_slot_index);
                    fails++;
                end
            end
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0] sz;
        int unsigned       sz_n;
        int unsigned       pool;
        logic              burst;
        int                drain_at;
        logic [KEY_W-1:0]  base;

        shadow_size = SIZE_RESET;
        for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;

        // Directed: wrap, collisions, duplicates, refusals, shrunk table
        add_req(OP_INSERT, 31'd1, 0);
        add_req(OP_INSERT, KEY_MAX, 1);
        add_req(OP_INSERT, 31'd16, 0);
        add_req(OP_INSERT, 31'd17, 2);
        add_req(OP_INSERT, 31'd15, 0);
        add_req(OP_SEARCH, 31'd15, 0);
        add_req(OP_SEARCH, 31'd99, 3);
        add_req(OP_DELETE, 31'd1, 0);
        add_req(OP_SEARCH, 31'd17, 0);
        add_req(OP_INSERT, 31'd1, 0);
        add_req(OP_INSERT, 31'd1, 0);
        add_req(OP_DELETE, 31'd2, 1);
        add_req(OP_INSERT, KEY_NONE, 0);
        add_req(OP_SEARCH, KEY_NONE, 0);
        add_req(OP_UNUSED, 31'd5, 0);
        add_req(OP_UNUSED, KEY_NONE, 0);
        add_req(OP_SEARCH, KEY_MAX, 0);
        add_req(OP_DELETE, KEY_MAX, 0);
        add_ctrl(WORD_CFG, 5'd1);
        add_req(OP_INSERT, 31'd5, 0);
        add_req(OP_SEARCH, 31'd16, 0);
        add_req(OP_DELETE, 31'd16, 0);
        add_req(OP_INSERT, 31'd7, 0);
        add_req(OP_INSERT, 31'd8, 0);
        add_ctrl(WORD_CFG, 5'd0);
        add_req(OP_SEARCH, 31'd7, 0);
        add_ctrl(WORD_CFG, 5'd31);
        add_req(OP_SEARCH, 31'd17, 0);

        // Random phases, each under its own table size
        size_plan = '{5'd2, 5'd16, 5'd17, 5'd5, 5'd0, 5'd3, 5'd31, 5'd1, 5'd8};
        for (int p = 0; p < PHASES; p++) begin
            if (p < size_plan.size()) sz = size_plan[p];
            else sz = SIZE_W'($urandom_range(0, 31));
            sz_n = (sz == 0) ? 1 : ((sz > DEPTH) ? DEPTH : 32'(sz));
            pool = sz_n + $urandom_range(1, 6);
            base = KEY_W'($urandom) & 31'h7FFF_FF00;
            burst = ($urandom_range(0, 3) == 0);
            drain_at = $urandom_range(20, 80);
            add_ctrl(WORD_CFG, sz);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i == drain_at) add_ctrl(WORD_DRAIN, '0);
                add_req(draw_op(), draw_key(pool, base),
                        burst ? 0 : $urandom_range(0, 5));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait out the stimulus, then the last results
        while (pending_q.size() > 0 || start || outcome_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
